// ===== hw/rtl/lct_pkg.sv =====
// Shared types and constants for the LFU cache table.
// Used by lct_cell and the top level lfu_cache_table; no dependencies.
package lct_pkg;

  // Widths fixed by the item format
  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;

  // Reset value of the capacity register
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Read data returned on a get that misses
  localparam logic [DATA_W-1:0] READ_MISS = 32'hFFFF_FFFF;

  // Action codes carried in the input tuser
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // Update command applied to the target cell
  typedef enum logic [1:0] {
    CMD_TOUCH,
    CMD_FILL,
    CMD_EVICT
  } cmd_mode_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

// ===== hw/rtl/lct_cell.sv =====
// One entry of the LFU cache table plus one stage of the lookup/victim chain.
// Depends on lct_pkg.
module lct_cell #(
  parameter int CAPACITY    = 16,
  parameter int COUNT_WIDTH = 16,
  parameter int INDEX       = 0,
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  // Flat widths of scan_t and cmd_t below
  localparam int SCAN_W = 4 + 5 * IDX_W + lct_pkg::DATA_W + COUNT_WIDTH,
  localparam int CMD_W  = 5 + 2 * IDX_W + 2 * lct_pkg::DATA_W
) (
  input  logic clk,
  input  logic rst,
  input  logic [lct_pkg::DATA_W-1:0] scan_key,
  input  logic [SCAN_W-1:0]          chain_in,
  output logic [SCAN_W-1:0]          chain_out,
  input  logic [CMD_W-1:0]           cmd_in
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef struct packed {
    logic                   tok;
    logic                   match;
    logic [IDX_W-1:0]       match_idx;
    logic [lct_pkg::DATA_W-1:0] match_val;
    logic [IDX_W-1:0]       match_rank;
    logic                   free_found;
    logic [IDX_W-1:0]       free_idx;
    logic                   vic_found;
    logic [IDX_W-1:0]       vic_idx;
    logic [COUNT_WIDTH-1:0] vic_count;
    logic [IDX_W-1:0]       vic_rank;
  } scan_t;

  typedef struct packed {
    logic                       en;
    lct_pkg::cmd_mode_t         mode;
    logic [IDX_W-1:0]           idx;
    logic                       wr_value;
    logic                       age_all;
    logic [IDX_W-1:0]           limit;
    logic [lct_pkg::DATA_W-1:0] key;
    logic [lct_pkg::DATA_W-1:0] value;
  } cmd_t;

  // Entry state
  logic                       valid;
  logic [lct_pkg::DATA_W-1:0] key;
  logic [lct_pkg::DATA_W-1:0] value;
  logic [COUNT_WIDTH-1:0]     count;
  logic [IDX_W-1:0]           rank;

  scan_t sin;
  scan_t snext;
  scan_t sout;
  cmd_t  cmd;
  logic  here_match;
  logic  take_victim;

  assign sin       = scan_t'(chain_in);
  assign cmd       = cmd_t'(cmd_in);
  assign chain_out = sout;

  // Fold this entry into the running lookup/victim record
  always_comb begin
    here_match  = valid && (key == scan_key);
    take_victim = valid && (!sin.vic_found || (count < sin.vic_count) ||
                  ((count == sin.vic_count) && (rank > sin.vic_rank)));
    snext = sin;
    if (!sin.match && here_match) begin
      snext.match      = 1'b1;
      snext.match_idx  = MY_IDX;
      snext.match_val  = value;
      snext.match_rank = rank;
    end
    if (!sin.free_found && !valid) begin
      snext.free_found = 1'b1;
      snext.free_idx   = MY_IDX;
    end
    if (take_victim) begin
      snext.vic_found = 1'b1;
      snext.vic_idx   = MY_IDX;
      snext.vic_count = count;
      snext.vic_rank  = rank;
    end
  end

  // Hand the record to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      sout <= '0;
    end else begin
      sout <= snext;
    end
  end

  // Apply the update command: rewrite the target, age the younger entries
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (cmd.en) begin
      if (cmd.idx == MY_IDX) begin
        case (cmd.mode)
          lct_pkg::CMD_TOUCH: begin
            if (count != COUNT_MAX) begin
              count <= count + COUNT_WIDTH'(1);
            end
            if (cmd.wr_value) begin
              value <= cmd.value;
            end
            rank <= '0;
          end
          lct_pkg::CMD_FILL: begin
            valid <= 1'b1;
            key   <= cmd.key;
            value <= cmd.value;
            count <= COUNT_WIDTH'(1);
            rank  <= '0;
          end
          lct_pkg::CMD_EVICT: begin
            key   <= cmd.key;
            value <= cmd.value;
            count <= COUNT_WIDTH'(1);
            rank  <= '0;
          end
          default: begin
            rank <= rank;
          end
        endcase
      end else if (valid && (cmd.age_all || (rank < cmd.limit))) begin
        rank <= rank + IDX_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/lfu_cache_table.sv =====
// Top level of the LFU cache table: controller, capacity register, result register
// and the chain of lct_cell entries. Depends on lct_pkg and lct_cell.
//
// Fully associative key/value store with least-frequently-used replacement and
// least-recently-used tie-break among equal use counts.
// Input channel s_*: tuser[0] = action (0 get, 1 put), tdata = {value, key}.
// Output channel m_*: tuser[0] = hit, tdata = read_value (value on a get hit,
// all ones on a get miss, zero on a put).
// Configuration: cfg_wr_en/cfg_wr_data write the capacity in use; values above
// CAPACITY act as CAPACITY, zero turns every put into a no-op.
// An item is taken only in the idle state. Its lookup record walks the chain of
// CAPACITY cells, one cell per cycle, then the update is applied to all cells at
// once and the result is registered. A new item is taken only after the update of
// the last one is applied.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and its update waits only until that register is free.
// Reset empties the table, clears all recency ranks and sets the capacity to 16.
module lfu_cache_table #(
  parameter int CAPACITY    = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] key, [63:32] value
  input  logic [0:0]  s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] read_value
  output logic [0:0]  m_tuser,   // [0] hit
  input  logic        cfg_wr_en,
  input  logic [lct_pkg::CFG_W-1:0] cfg_wr_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (OCC_W > lct_pkg::CFG_W) ? OCC_W : lct_pkg::CFG_W;
  localparam int DW    = lct_pkg::DATA_W;

  typedef struct packed {
    logic                   tok;
    logic                   match;
    logic [IDX_W-1:0]       match_idx;
    logic [DW-1:0]          match_val;
    logic [IDX_W-1:0]       match_rank;
    logic                   free_found;
    logic [IDX_W-1:0]       free_idx;
    logic                   vic_found;
    logic [IDX_W-1:0]       vic_idx;
    logic [COUNT_WIDTH-1:0] vic_count;
    logic [IDX_W-1:0]       vic_rank;
  } scan_t;

  typedef struct packed {
    logic               en;
    lct_pkg::cmd_mode_t mode;
    logic [IDX_W-1:0]   idx;
    logic               wr_value;
    logic               age_all;
    logic [IDX_W-1:0]   limit;
    logic [DW-1:0]      key;
    logic [DW-1:0]      value;
  } cmd_t;

  lct_pkg::state_t state;
  lct_pkg::state_t state_next;

  logic [lct_pkg::CFG_W-1:0] capacity;
  logic [OCC_W-1:0]          occ;
  logic                      start;
  logic                      action_r;
  logic [DW-1:0]             key_r;
  logic [DW-1:0]             value_r;
  scan_t                     res;

  scan_t seed;
  scan_t chain [CAPACITY];
  cmd_t  cmd;

  logic            accept;
  logic            fire;
  logic            fill;
  logic            res_hit;
  logic [DW-1:0]   res_read;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_sat;
  logic [CMP_W-1:0] occ_ext;

  assign accept = s_tvalid && s_tready;

  // Seed record enters the first cell in the cycle after acceptance
  always_comb begin
    seed     = '0;
    seed.tok = start;
  end

  // Chain of entry cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      lct_cell #(
        .CAPACITY    (CAPACITY),
        .COUNT_WIDTH (COUNT_WIDTH),
        .INDEX       (i)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .scan_key  (key_r),
        .chain_in  (seed),
        .chain_out (chain[i]),
        .cmd_in    (cmd)
      );
    end else begin : g_next
      lct_cell #(
        .CAPACITY    (CAPACITY),
        .COUNT_WIDTH (COUNT_WIDTH),
        .INDEX       (i)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .scan_key  (key_r),
        .chain_in  (chain[i-1]),
        .chain_out (chain[i]),
        .cmd_in    (cmd)
      );
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lct_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = lct_pkg::ST_SCAN;
        end
      end
      lct_pkg::ST_SCAN: begin
        if (chain[CAPACITY-1].tok) begin
          state_next = lct_pkg::ST_UPDATE;
        end
      end
      lct_pkg::ST_UPDATE: begin
        if (!m_tvalid || m_tready) begin
          state_next = lct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lct_pkg::ST_IDLE;
      end
    endcase
  end

  // Decide the update and the result from the finished record
  always_comb begin
    cap_ext  = CMP_W'(capacity);
    cap_sat  = (cap_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_ext;
    occ_ext  = CMP_W'(occ);
    s_tready = (state == lct_pkg::ST_IDLE);
    fire     = (state == lct_pkg::ST_UPDATE) && (!m_tvalid || m_tready);
    fill     = 1'b0;
    res_hit  = res.match;
    res_read = '0;
    cmd          = '0;
    cmd.mode     = lct_pkg::CMD_TOUCH;
    cmd.key      = key_r;
    cmd.value    = value_r;
    if (action_r == lct_pkg::ACT_GET) begin
      if (res.match) begin
        res_read  = res.match_val;
        cmd.en    = fire;
        cmd.idx   = res.match_idx;
        cmd.limit = res.match_rank;
      end else begin
        res_read = lct_pkg::READ_MISS;
      end
    end else if (cap_sat != '0) begin
      if (res.match) begin
        cmd.en       = fire;
        cmd.idx      = res.match_idx;
        cmd.limit    = res.match_rank;
        cmd.wr_value = 1'b1;
      end else if ((occ_ext < cap_sat) && res.free_found) begin
        fill        = fire;
        cmd.en      = fire;
        cmd.mode    = lct_pkg::CMD_FILL;
        cmd.idx     = res.free_idx;
        cmd.age_all = 1'b1;
      end else if (res.vic_found) begin
        cmd.en    = fire;
        cmd.mode  = lct_pkg::CMD_EVICT;
        cmd.idx   = res.vic_idx;
        cmd.limit = res.vic_rank;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lct_pkg::ST_IDLE;
      start    <= 1'b0;
      capacity <= lct_pkg::CFG_RESET;
      occ      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      start <= accept;
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (fill) begin
        occ <= occ + OCC_W'(1);
      end
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers: hold the item, the finished record and the result
  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= s_tuser[0];
      key_r    <= s_tdata[31:0];
      value_r  <= s_tdata[63:32];
    end
    if ((state == lct_pkg::ST_SCAN) && chain[CAPACITY-1].tok) begin
      res <= chain[CAPACITY-1];
    end
    if (fire) begin
      m_tdata    <= res_read;
      m_tuser[0] <= res_hit;
    end
  end

endmodule
